### rtl/acpfd_pkg.sv
// shared types, constants and register indexes of the ac phase/frequency detector
`timescale 1ns / 1ps

package acpfd_pkg;

	localparam int SAMPLE_W     = 12;
	localparam int CENTER_W     = 12;
	localparam int HYST_W       = 8;
	localparam int MINP_W       = 16;
	localparam int WMS_W        = 16;
	localparam int FREQ_W       = 20;
	localparam int PHASE_W      = 11;
	localparam int PERIOD_W     = 20;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int COUNT_W_DEF  = 20;

	localparam int FREQ_SCALE_W = 20;
	localparam logic [FREQ_SCALE_W-1:0] FREQ_SCALE = 20'd1000000;
	localparam logic [FREQ_W-1:0]       FREQ_MAX   = 20'd1000000;
	localparam logic [11:0]             PHASE_SCALE = 12'd3600;

	// divider step counts: extra leading steps on frequency, the topmost flags overflow
	localparam int FREQ_STEPS  = FREQ_W + 2;
	localparam int PHASE_STEPS = PHASE_W;

	localparam logic [CFG_IDX_W-1:0] REG_VOLT_CENTER     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CURR_CENTER     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNALS_PRESENT = 3'd4;

	typedef struct packed {
		logic [SAMPLE_W-1:0] volt_sample;
		logic [SAMPLE_W-1:0] curr_sample;
		logic                last;
		logic [WMS_W-1:0]    window_ms;
	} sample_req_t;

	typedef struct packed {
		logic                valid_res;
		logic [FREQ_W-1:0]   freq_mhz;
		logic [PHASE_W-1:0]  phase_tenths;
		logic [PERIOD_W-1:0] period_count;
	} result_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DEN,
		ST_NUMF,
		ST_DIVF,
		ST_MOD,
		ST_NUMP,
		ST_DIVP,
		ST_FIN
	} seq_state_t;

endpackage

### rtl/acpfd_xdet.sv
// rising zero-crossing detector with hysteresis for one adc channel
`timescale 1ns / 1ps

module acpfd_xdet (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            clr,
	input  logic [acpfd_pkg::SAMPLE_W-1:0]  sample,
	input  logic [acpfd_pkg::CENTER_W-1:0]  center,
	input  logic [acpfd_pkg::HYST_W-1:0]    hyst,
	output logic                            fire
);
	import acpfd_pkg::*;

	localparam int CMP_W = ((SAMPLE_W > CENTER_W) ? SAMPLE_W : CENTER_W) + 1;

	logic             armed_q;
	logic             can_arm;
	logic             arm_now;
	logic [CMP_W-1:0] lo_thr;
	logic [CMP_W-1:0] hi_thr;

	// lower threshold only exists when center sits at or above hysteresis
	assign can_arm = center >= CENTER_W'(hyst);
	assign lo_thr  = CMP_W'(center) - CMP_W'(hyst);
	assign hi_thr  = CMP_W'(center) + CMP_W'(hyst);
	assign arm_now = armed_q | (can_arm & (CMP_W'(sample) < lo_thr));
	assign fire    = arm_now & (CMP_W'(sample) > hi_thr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
		end else if (clr) begin
			armed_q <= 1'b0;
		end else if (en) begin
			armed_q <= arm_now & ~fire;
		end
	end

endmodule

### rtl/acpfd_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module acpfd_div #(
	parameter int REM_W = 41,
	parameter int DSR_W = 57,
	parameter int QUO_W = 22,
	parameter int STP_W = $clog2(QUO_W + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [REM_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,   // already aligned to the top quotient bit
	input  logic [STP_W-1:0] steps,
	output logic             done,
	output logic [QUO_W-1:0] quot,
	output logic [REM_W-1:0] rem
);

	logic [REM_W-1:0] rem_q;
	logic [DSR_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [STP_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;

	assign ge   = DSR_W'(rem_q) >= dsh_q;
	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == STP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[REM_W-1:0];
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

### rtl/ac_phase_frequency_detector.sv
// top level of the ac phase and frequency detector
`timescale 1ns / 1ps

// Measures line frequency and voltage/current phase over one window of paired
// adc samples. Sample requests are taken only while the sequencer is idle: both
// channels run a hysteresis rising-crossing detector and the window registers
// record the first two voltage crossings (the second only when it lies more than
// min_period samples after the first) and the first current crossing. The
// request flagged last closes the window and sample_stall stays high until the
// result is loaded. For a valid measurement a small sequencer drives one shared
// multiplier and one shared one-bit-per-cycle restoring divider through three
// divisions: frequency (22 steps, the leading step flags saturation), the
// crossing offset modulo the period (COUNT_WIDTH steps) and the phase scaling
// (11 steps). The result request is held in an output register, so a waiting
// result only delays the sequencer when the next window closes before it is
// taken. An invalid measurement (signals absent, missing crossings) skips the
// arithmetic and gives valid_res low and zero fields.
module ac_phase_frequency_detector #(
	parameter int COUNT_WIDTH = acpfd_pkg::COUNT_W_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [acpfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [acpfd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  acpfd_pkg::sample_req_t            sample_req,
	output logic                              result_valid,
	input  logic                              result_stall,
	output acpfd_pkg::result_req_t            result_req
);
	import acpfd_pkg::*;

	localparam int CW    = COUNT_WIDTH;
	localparam int GAP_W = (CW > MINP_W) ? CW : MINP_W;
	localparam int MUL_A = CW + 1;
	localparam int PRD_W = CW + 1 + FREQ_SCALE_W;    // widest product
	localparam int DEN_W = CW + WMS_W;
	localparam int REM_W = PRD_W;                    // widest dividend
	localparam int DSR_W = DEN_W + FREQ_STEPS - 1;   // widest aligned divisor
	localparam int QUO_W = (CW > FREQ_STEPS) ? CW : FREQ_STEPS;
	localparam int STP_W = $clog2(QUO_W + 1);

	// configuration registers
	logic [CENTER_W-1:0] volt_center_q;
	logic [CENTER_W-1:0] curr_center_q;
	logic [HYST_W-1:0]   hysteresis_q;
	logic [MINP_W-1:0]   min_period_q;
	logic                signals_present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_center_q     <= CENTER_W'(2048);
			curr_center_q     <= CENTER_W'(2048);
			hysteresis_q      <= HYST_W'(30);
			min_period_q      <= MINP_W'(100);
			signals_present_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VOLT_CENTER:     volt_center_q     <= cfg_data[CENTER_W-1:0];
				REG_CURR_CENTER:     curr_center_q     <= cfg_data[CENTER_W-1:0];
				REG_HYSTERESIS:      hysteresis_q      <= cfg_data[HYST_W-1:0];
				REG_MIN_PERIOD:      min_period_q      <= cfg_data[MINP_W-1:0];
				REG_SIGNALS_PRESENT: signals_present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer state and window registers
	seq_state_t state_q, state_nxt;

	logic          take;
	logic          win_clr;
	logic          volt_fire;
	logic          curr_fire;
	logic [1:0]    volt_cross_num_q;
	logic          curr_cross_num_q;
	logic [CW-1:0] volt_first_at_q;
	logic [CW-1:0] volt_second_at_q;
	logic [CW-1:0] curr_first_at_q;
	logic [CW-1:0] sample_index_q;
	logic [WMS_W-1:0] window_ms_q;
	logic          spacing_ok;

	assign take = sample_valid & ~sample_stall;

	acpfd_xdet u_volt_xdet (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (take),
		.clr    (win_clr),
		.sample (sample_req.volt_sample),
		.center (volt_center_q),
		.hyst   (hysteresis_q),
		.fire   (volt_fire)
	);

	acpfd_xdet u_curr_xdet (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (take),
		.clr    (win_clr),
		.sample (sample_req.curr_sample),
		.center (curr_center_q),
		.hyst   (hysteresis_q),
		.fire   (curr_fire)
	);

	// second voltage crossing must lie strictly beyond min_period
	assign spacing_ok = GAP_W'(sample_index_q - volt_first_at_q) > GAP_W'(min_period_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_cross_num_q <= 2'd0;
			curr_cross_num_q <= 1'b0;
			volt_first_at_q  <= '0;
			volt_second_at_q <= '0;
			curr_first_at_q  <= '0;
			sample_index_q   <= '0;
		end else if (win_clr) begin
			volt_cross_num_q <= 2'd0;
			curr_cross_num_q <= 1'b0;
			volt_first_at_q  <= '0;
			volt_second_at_q <= '0;
			curr_first_at_q  <= '0;
			sample_index_q   <= '0;
		end else if (take) begin
			if (volt_fire) begin
				if (volt_cross_num_q == 2'd0) begin
					volt_first_at_q  <= sample_index_q;
					volt_cross_num_q <= 2'd1;
				end else if (volt_cross_num_q == 2'd1 && spacing_ok) begin
					volt_second_at_q <= sample_index_q;
					volt_cross_num_q <= 2'd2;
				end
			end
			if (curr_fire && !curr_cross_num_q) begin
				curr_first_at_q  <= sample_index_q;
				curr_cross_num_q <= 1'b1;
			end
			// index holds on the last request: n is taken from it afterwards
			if (!sample_req.last && sample_index_q != {CW{1'b1}}) begin
				sample_index_q <= sample_index_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && sample_req.last) begin
			window_ms_q <= sample_req.window_ms;
		end
	end

	// values derived from the closed window
	logic          meas_ok;
	logic [CW-1:0] period;
	logic [CW-1:0] half_period;
	logic [CW:0]   offset;
	logic [CW-1:0] offset_abs;
	logic [CW:0]   n_samples;

	assign meas_ok     = signals_present_q & (volt_cross_num_q == 2'd2) & curr_cross_num_q;
	assign period      = volt_second_at_q - volt_first_at_q;
	assign half_period = period >> 1;
	assign offset      = {1'b0, curr_first_at_q} - {1'b0, volt_first_at_q};
	assign offset_abs  = offset[CW] ? CW'(-offset) : offset[CW-1:0];
	assign n_samples   = {1'b0, sample_index_q} + 1'b1;

	// shared multiplier and divider
	logic                    mul_en;
	logic [MUL_A-1:0]        mul_a;
	logic [FREQ_SCALE_W-1:0] mul_b;
	logic [PRD_W-1:0]        prod_q;
	logic [DEN_W-1:0]        den_q;

	logic             div_start;
	logic [REM_W-1:0] div_dividend;
	logic [DSR_W-1:0] div_divisor;
	logic [STP_W-1:0] div_steps;
	logic             div_done;
	logic [QUO_W-1:0] div_quot;
	logic [REM_W-1:0] div_rem;

	acpfd_div #(
		.REM_W (REM_W),
		.DSR_W (DSR_W),
		.QUO_W (QUO_W),
		.STP_W (STP_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// folded offset: distance to the nearest whole period
	logic [CW-1:0] mod_r;
	logic [CW-1:0] fold_abs;
	assign mod_r    = div_rem[CW-1:0];
	assign fold_abs = (mod_r <= half_period) ? mod_r : period - mod_r;

	// frequency saturation: overflow step set or quotient above full scale
	logic              freq_sat;
	logic [FREQ_W-1:0] freq_val;
	assign freq_sat = div_quot[FREQ_STEPS-1]
		| (div_quot[FREQ_STEPS-2:0] > (FREQ_STEPS-1)'(FREQ_MAX));
	assign freq_val = freq_sat ? FREQ_MAX : div_quot[FREQ_W-1:0];

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_DEN) begin
			den_q <= prod_q[DEN_W-1:0];
		end
	end

	// result registers
	logic               ok_q;
	logic [FREQ_W-1:0]  freq_q;
	logic [PHASE_W-1:0] phase_q;
	logic               res_load;
	logic               res_valid_q;
	result_req_t        res_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			ok_q <= meas_ok;
		end
		if (state_q == ST_DIVF && div_done) begin
			freq_q <= freq_val;
		end
		if (state_q == ST_DIVP && div_done) begin
			phase_q <= div_quot[PHASE_W-1:0];
		end
		if (res_load) begin
			res_q.valid_res    <= ok_q;
			res_q.freq_mhz     <= ok_q ? freq_q : '0;
			res_q.phase_tenths <= ok_q ? phase_q : '0;
			res_q.period_count <= ok_q ? PERIOD_W'(period) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result_valid = res_valid_q;
	assign result_req   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (take && sample_req.last) state_nxt = ST_CHECK;
			ST_CHECK: state_nxt = meas_ok ? ST_DEN : ST_FIN;
			ST_DEN:   state_nxt = ST_NUMF;
			ST_NUMF:  state_nxt = ST_DIVF;
			ST_DIVF:  if (div_done) state_nxt = ST_MOD;
			ST_MOD:   if (div_done) state_nxt = ST_NUMP;
			ST_NUMP:  state_nxt = ST_DIVP;
			ST_DIVP:  if (div_done) state_nxt = ST_FIN;
			ST_FIN:   if (!res_valid_q || !result_stall) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample_stall = 1'b1;
		res_load     = 1'b0;
		win_clr      = 1'b0;
		mul_en       = 1'b0;
		mul_a        = MUL_A'(period);
		mul_b        = FREQ_SCALE_W'(window_ms_q);
		div_start    = 1'b0;
		div_dividend = prod_q + REM_W'(den_q >> 1);
		div_divisor  = DSR_W'(den_q) << (FREQ_STEPS - 1);
		div_steps    = STP_W'(FREQ_STEPS);
		case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
			end
			ST_CHECK: begin
				// denominator p * window_ms
				mul_en = meas_ok;
			end
			ST_DEN: begin
				mul_en = 1'b1;
				mul_a  = n_samples;
				mul_b  = FREQ_SCALE;
			end
			ST_NUMF: begin
				// (n * 1e6 + den / 2) / den
				div_start = 1'b1;
			end
			ST_DIVF: begin
				// |offset| modulo period
				div_start    = div_done;
				div_dividend = REM_W'(offset_abs);
				div_divisor  = DSR_W'(period) << (CW - 1);
				div_steps    = STP_W'(CW);
			end
			ST_MOD: begin
				mul_en = div_done;
				mul_a  = MUL_A'(fold_abs);
				mul_b  = FREQ_SCALE_W'(PHASE_SCALE);
			end
			ST_NUMP: begin
				// (fold_abs * 3600 + p / 2) / p
				div_start    = 1'b1;
				div_dividend = prod_q + REM_W'(half_period);
				div_divisor  = DSR_W'(period) << (PHASE_STEPS - 1);
				div_steps    = STP_W'(PHASE_STEPS);
			end
			ST_DIVP: ;
			ST_FIN: begin
				res_load = !res_valid_q || !result_stall;
				win_clr  = res_load;
			end
			default: ;
		endcase
	end

endmodule

### tb/tb_ac_phase_frequency_detector.sv
// self-checking testbench for the ac phase and frequency detector
`timescale 1ns / 1ps

module tb_ac_phase_frequency_detector;
	import acpfd_pkg::*;

	localparam int     CNT_W   = COUNT_W_DEF;
	localparam longint IDX_MAX = (longint'(1) << CNT_W) - 1;
	// time for a window close to finish, plus a little slack
	localparam int     SETTLE  = CNT_W + 41 + 8;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	sample_req_t           sample_req   = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_req_t           result_req;

	ac_phase_frequency_detector uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_req   (sample_req),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_req   (result_req)
	);

	// sample requests waiting to be driven, measurements waiting to come out
	sample_req_t sample_backlog[$];
	result_req_t pending_meas[$];

	int errors  = 0;
	int tx_idle = 10;    // percent of cycles the sample side holds back
	int rx_idle = 50;    // percent of cycles the result side stalls
	bit took    = 1'b0;  // sample request accepted at the last rising edge

	// shadow copy of the configuration registers
	int cen_v  = 2048;
	int cen_c  = 2048;
	int hys    = 30;
	int minp   = 100;
	bit sig_on = 1'b1;

	// shadow copy of the window state
	bit     v_armed = 1'b0;
	bit     c_armed = 1'b0;
	bit     c_seen  = 1'b0;
	int     v_hits  = 0;
	longint v_first = 0;
	longint v_second = 0;
	longint c_first = 0;
	longint win_idx = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// rising-crossing detector: returns {armed after, fired}
	function automatic logic [1:0] hyst_edge(input bit armed, input int s, input int ctr);
		bit a;
		bit f;
		a = armed;
		f = 1'b0;
		// lower threshold only exists when center sits at or above the hysteresis
		if (ctr >= hys && s < ctr - hys)
			a = 1'b1;
		if (a && s > ctr + hys) begin
			a = 1'b0;
			f = 1'b1;
		end
		return {a, f};
	endfunction

	// advance the window by one sample pair, queue a measurement on the last one
	task automatic meter_step(input sample_req_t r);
		logic [1:0]  e;
		longint      idx, n, p, den, d, half, ad;
		result_req_t m;
		idx = win_idx;
		e = hyst_edge(v_armed, int'(r.volt_sample), cen_v);
		v_armed = e[1];
		if (e[0]) begin
			if (v_hits == 0) begin
				v_first = idx;
				v_hits  = 1;
			end else if (v_hits == 1 && idx - v_first > minp) begin
				v_second = idx;
				v_hits   = 2;
			end
		end
		e = hyst_edge(c_armed, int'(r.curr_sample), cen_c);
		c_armed = e[1];
		if (e[0] && !c_seen) begin
			c_first = idx;
			c_seen  = 1'b1;
		end
		if (!r.last) begin
			// index sticks at all ones on very long windows
			if (win_idx < IDX_MAX)
				win_idx++;
		end else begin
			m = '0;
			if (sig_on && v_hits == 2 && c_seen) begin
				n    = idx + 1;
				p    = v_second - v_first;
				den  = p * longint'(r.window_ms);
				d    = c_first - v_first;
				half = p / 2;
				m.valid_res    = 1'b1;
				m.period_count = p[PERIOD_W-1:0];
				// zero window time saturates, as does any frequency above range
				if (den == 0)
					m.freq_mhz = FREQ_MAX;
				else if ((n * 1000000 + den / 2) / den > 1000000)
					m.freq_mhz = FREQ_MAX;
				else
					m.freq_mhz = FREQ_W'((n * 1000000 + den / 2) / den);
				// fold the crossing offset into half a period either side
				if (d > half)
					d -= ((d - half + p - 1) / p) * p;
				if (d < -half)
					d += ((-half - d + p - 1) / p) * p;
				ad = (d < 0) ? -d : d;
				m.phase_tenths = PHASE_W'((ad * 3600 + p / 2) / p);
			end
			pending_meas.push_back(m);
			v_armed  = 1'b0;
			c_armed  = 1'b0;
			c_seen   = 1'b0;
			v_hits   = 0;
			v_first  = 0;
			v_second = 0;
			c_first  = 0;
			win_idx  = 0;
		end
	endtask

	task automatic check_field(input string tag, input longint want, input longint got);
		if (want != got) begin
			errors++;
			$display("%0t %s mismatch: expected %0d actual %0d", $time, tag, want, got);
		end
	endtask

	// sample side: new request only once the previous one has gone
	always @(negedge clk) begin
		if (arst_n) begin
			if (!sample_valid || took) begin
				if (sample_backlog.size() != 0 && $urandom_range(99) >= tx_idle) begin
					sample_req   <= sample_backlog.pop_front();
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
				end
			end
			result_stall <= ($urandom_range(99) < rx_idle);
		end
	end

	// monitor: track register writes, predict on accepted samples, check results
	always @(posedge clk) begin
		result_req_t m;
		if (arst_n) begin
			took <= sample_valid && !sample_stall;
			if (cfg_we) begin
				case (cfg_index)
					REG_VOLT_CENTER:     cen_v  = int'(cfg_data[CENTER_W-1:0]);
					REG_CURR_CENTER:     cen_c  = int'(cfg_data[CENTER_W-1:0]);
					REG_HYSTERESIS:      hys    = int'(cfg_data[HYST_W-1:0]);
					REG_MIN_PERIOD:      minp   = int'(cfg_data[MINP_W-1:0]);
					REG_SIGNALS_PRESENT: sig_on = cfg_data[0];
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall)
				meter_step(sample_req);
			if (result_valid && !result_stall) begin
				if (pending_meas.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none actual %h", $time,
						result_req);
				end else begin
					m = pending_meas.pop_front();
					check_field("valid_res", m.valid_res, result_req.valid_res);
					check_field("freq_mhz", m.freq_mhz, result_req.freq_mhz);
					check_field("phase_tenths", m.phase_tenths, result_req.phase_tenths);
					check_field("period_count", m.period_count, result_req.period_count);
				end
			end
		end
	end

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// keep the backlog short so very long windows need little memory
	task automatic queue_sample(input int v, input int c, input bit lst, input int ms);
		sample_req_t r;
		while (sample_backlog.size() >= 512)
			@(posedge clk);
		r.volt_sample = SAMPLE_W'(v);
		r.curr_sample = SAMPLE_W'(c);
		r.last        = lst;
		r.window_ms   = WMS_W'(ms);
		sample_backlog.push_back(r);
	endtask

	// hold the sender until every measurement is out and the block is quiet
	task automatic settle_idle();
		do
			@(posedge clk);
		while (sample_backlog.size() != 0 || sample_valid || pending_meas.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// a level just past the arm or fire threshold, clipped to the adc range
	function automatic int swing(input int ctr, input bit hi, input int spread);
		int v;
		if (hi)
			v = ctr + hys + 1 + int'($urandom_range(spread));
		else
			v = ctr - hys - 1 - int'($urandom_range(spread));
		return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
	endfunction

	function automatic int pick_ms();
		case ($urandom_range(9))
			0:       return 0;
			1:       return 65535;
			2:       return int'($urandom_range(65535));
			default: return int'($urandom_range(5, 400));
		endcase
	endfunction

	// square waves on both channels with random phase and amplitude spread
	task automatic square_window(input int per, input int len, input int ms);
		int voff, coff, spread, k;
		voff   = int'($urandom_range(per - 1));
		coff   = int'($urandom_range(per - 1));
		spread = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(600));
		for (k = 0; k < len; k++)
			queue_sample(swing(cen_v, ((k + voff) % per) >= per / 2, spread),
				swing(cen_c, ((k + coff) % per) >= per / 2, spread),
				k == len - 1, (k == len - 1) ? ms : int'($urandom_range(65535)));
	endtask

	task automatic noise_window();
		int len, k;
		len = int'($urandom_range(1, 30));
		for (k = 0; k < len; k++)
			queue_sample(int'($urandom_range(4095)), int'($urandom_range(4095)),
				k == len - 1, int'($urandom_range(65535)));
	endtask

	initial begin
		int s, w, per, cv, cc, hv, mp, sp;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		tx_idle = 10;
		rx_idle = 50;

		// directed: rail-to-rail samples, shortest possible period
		reg_write(REG_MIN_PERIOD, 0);
		// zero window time, frequency saturates
		queue_sample(0, 0, 1'b0, 0);
		queue_sample(4095, 4095, 1'b0, 0);
		queue_sample(0, 0, 1'b0, 0);
		queue_sample(4095, 4095, 1'b1, 0);
		// widest window time, current half a period behind
		queue_sample(0, 4095, 1'b0, 65535);
		queue_sample(4095, 0, 1'b0, 65535);
		queue_sample(0, 4095, 1'b0, 65535);
		queue_sample(4095, 4095, 1'b1, 65535);
		// window of one request, no crossings
		queue_sample(4095, 4095, 1'b1, 1000);
		// current leads voltage, negative offset
		queue_sample(0, 0, 1'b0, 3);
		queue_sample(0, 4095, 1'b0, 3);
		queue_sample(4095, 0, 1'b0, 3);
		queue_sample(0, 0, 1'b0, 3);
		queue_sample(0, 0, 1'b0, 3);
		queue_sample(0, 0, 1'b0, 3);
		queue_sample(4095, 0, 1'b1, 3);
		// signals absent forces an invalid result
		settle_idle();
		reg_write(REG_SIGNALS_PRESENT, 0);
		queue_sample(0, 0, 1'b0, 100);
		queue_sample(4095, 4095, 1'b0, 100);
		queue_sample(0, 0, 1'b0, 100);
		queue_sample(4095, 4095, 1'b1, 100);

		// random windows over a range of register settings
		for (s = 0; s < 10; s++) begin
			settle_idle();
			if (s == 4) begin
				tx_idle = 50;
				rx_idle = 10;
			end
			if (s == 7) begin
				tx_idle = 0;
				rx_idle = 0;
			end
			case (s)
				0: begin cv = 2048; cc = 2048; hv = 30;  mp = 2;     sp = 1; end
				// centers at the rails, no hysteresis
				1: begin cv = 0;    cc = 4095; hv = 0;   mp = 0;     sp = 1; end
				// center below hysteresis, lower threshold never arms
				2: begin cv = 10;   cc = 20;   hv = 30;  mp = 1;     sp = 1; end
				3: begin cv = 4095; cc = 0;    hv = 255; mp = 65535; sp = 1; end
				7: begin cv = 2048; cc = 2048; hv = 255; mp = 3;     sp = 1; end
				default: begin
					cv = int'($urandom_range(300, 3800));
					cc = int'($urandom_range(300, 3800));
					hv = int'($urandom_range(255));
					mp = int'($urandom_range(4));
					sp = (s == 5) ? 0 : 1;
				end
			endcase
			reg_write(REG_VOLT_CENTER, cv);
			reg_write(REG_CURR_CENTER, cc);
			reg_write(REG_HYSTERESIS, hv);
			reg_write(REG_MIN_PERIOD, mp);
			reg_write(REG_SIGNALS_PRESENT, sp);
			for (w = 0; w < 4; w++) begin
				per = int'($urandom_range(2, 8));
				if (w < 3)
					square_window(per, int'($urandom_range(2 * per + 1, 4 * per + 2)),
						pick_ms());
				else if ($urandom_range(1) == 0)
					noise_window();
				// broken window: closes before the second crossing
				else
					square_window(per, int'($urandom_range(1, per)), pick_ms());
			end
		end

		settle_idle();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### sim.f
rtl/acpfd_pkg.sv
rtl/acpfd_xdet.sv
rtl/acpfd_div.sv
rtl/ac_phase_frequency_detector.sv
tb/tb_ac_phase_frequency_detector.sv
